// ----- rtl/core/rle_image_blit_decoder_defines.svh -----
// Assertion macros for the RLE image blit decoder.
`ifndef RLE_IMAGE_BLIT_DECODER_DEFINES_SVH
`define RLE_IMAGE_BLIT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define RIB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RIB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RIB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define RIB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/rib_pkg.sv -----
// Shared types and constants of the RLE image blit decoder.
package rib_pkg;

   localparam int ADDR_BITS_DEF = 24;
   localparam int CMD_DEPTH     = 4;
   localparam int OUT_DEPTH     = 2;

   localparam int BYTE_W     = 8;
   localparam int DIM_W      = 16;
   localparam int BASE_W     = 24;
   localparam int PITCH_W    = 16;
   localparam int PIX_ADDR_W = 24;
   localparam int RUN_W      = 6;
   localparam int HIDX_W     = 3;
   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 1;

   localparam logic [BYTE_W-1:0] RUN_MIN   = 8'hC1;
   localparam logic [HIDX_W-1:0] HDR_BYTES = 3'd4;

   // header byte positions
   localparam logic [HIDX_W-1:0] HDR_W_LO = 3'd0;
   localparam logic [HIDX_W-1:0] HDR_W_HI = 3'd1;
   localparam logic [HIDX_W-1:0] HDR_H_LO = 3'd2;
   localparam logic [HIDX_W-1:0] HDR_H_HI = 3'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PITCH = 1'd1;

   // command from the front end to the back end
   typedef struct packed {
      logic                is_hdr;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [BASE_W-1:0]   base;
      logic [BYTE_W-1:0]   value;
      logic [RUN_W-1:0]    count;
   } cmd_type;

   // one emitted pixel
   typedef struct packed {
      logic [PIX_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     value;
      logic                  last;
      logic                  done;
   } pix_type;

endpackage

// ----- rtl/core/rib_fifo.sv -----
// Small register-based FIFO used between the decoder stages.
module rib_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_fire, rd_fire;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_fire = wr_en && !full;
   assign rd_fire = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
         count_in = count_ff + 1'b1;
      end else if (rd_fire && !wr_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/rib_front.sv -----
// Front end: header parse and run/literal classification of source bytes.
module rib_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_fire,
   input  logic [rib_pkg::BYTE_W-1:0]    byte_in,
   input  logic                          frame_start,
   input  logic [rib_pkg::BASE_W-1:0]    dest_base,
   output logic                          cmd_push,
   output rib_pkg::cmd_type              cmd_data
);

   logic                          active_ff, active_in;
   logic [rib_pkg::HIDX_W-1:0]    hidx_ff, hidx_in;
   logic [rib_pkg::DIM_W-1:0]     width_ff, width_in;
   logic [rib_pkg::DIM_W-1:0]     height_ff, height_in;
   logic                          await_ff, await_in;
   logic [rib_pkg::RUN_W-1:0]     run_ff, run_in;

   logic                          eff_active;
   logic [rib_pkg::HIDX_W-1:0]    eff_hidx;
   logic                          eff_await;

   always_comb begin
      eff_active = frame_start || active_ff;
      eff_hidx   = frame_start ? '0 : hidx_ff;
      eff_await  = frame_start ? 1'b0 : await_ff;

      active_in = active_ff;
      hidx_in   = hidx_ff;
      width_in  = width_ff;
      height_in = height_ff;
      await_in  = await_ff;
      run_in    = run_ff;
      cmd_push  = 1'b0;
      cmd_data  = '0;

      if (in_fire && eff_active) begin
         active_in = 1'b1;
         hidx_in   = eff_hidx;
         await_in  = eff_await;
         if (eff_hidx < rib_pkg::HDR_BYTES) begin
            case (eff_hidx)
               rib_pkg::HDR_W_LO: width_in  = {8'h00, byte_in};
               rib_pkg::HDR_W_HI: width_in  = {byte_in, width_ff[7:0]};
               rib_pkg::HDR_H_LO: height_in = {8'h00, byte_in};
               rib_pkg::HDR_H_HI: height_in = {byte_in, height_ff[7:0]};
               default:           height_in = height_ff;
            endcase
            hidx_in = eff_hidx + 1'b1;
            if (eff_hidx == rib_pkg::HDR_H_HI) begin
               cmd_push        = 1'b1;
               cmd_data.is_hdr = 1'b1;
               cmd_data.width  = width_ff;
               cmd_data.height = {byte_in, height_ff[7:0]};
               cmd_data.base   = dest_base;
               await_in        = 1'b0;
            end
         end else if (eff_await) begin
            cmd_push       = 1'b1;
            cmd_data.value = byte_in;
            cmd_data.count = run_ff;
            await_in       = 1'b0;
         end else if (byte_in >= rib_pkg::RUN_MIN) begin
            // run byte: count is the byte minus 0xC0
            await_in = 1'b1;
            run_in   = byte_in[rib_pkg::RUN_W-1:0];
         end else begin
            cmd_push       = 1'b1;
            cmd_data.value = byte_in;
            cmd_data.count = rib_pkg::RUN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         hidx_ff   <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         await_ff  <= 1'b0;
         run_ff    <= '0;
      end else begin
         active_ff <= active_in;
         hidx_ff   <= hidx_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         await_ff  <= await_in;
         run_ff    <= run_in;
      end
   end

endmodule

// ----- rtl/core/rib_back.sv -----
// Back end: run expansion and destination address generation.
module rib_back #(
   parameter int ADDR_BITS = rib_pkg::ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rib_pkg::cmd_type              cmd_head,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   input  logic [rib_pkg::PITCH_W-1:0]   row_pitch,
   input  logic                          out_full,
   output logic                          out_push,
   output rib_pkg::pix_type              out_data
);

   logic [rib_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [rib_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [rib_pkg::DIM_W-1:0]  col_ff, col_in;
   logic [rib_pkg::DIM_W-1:0]  row_ff, row_in;
   logic [ADDR_BITS-1:0]       raddr_ff, raddr_in;
   logic                       finished_ff, finished_in;
   logic                       busy_ff, busy_in;
   logic [rib_pkg::BYTE_W-1:0] value_ff, value_in;
   logic [rib_pkg::RUN_W-1:0]  rem_ff, rem_in;

   logic [rib_pkg::BYTE_W-1:0] sel_value;
   logic [rib_pkg::RUN_W-1:0]  sel_rem;
   logic [rib_pkg::DIM_W-1:0]  col_inc, row_inc;
   logic [ADDR_BITS-1:0]       pix_addr;
   logic                       wrap, done, last, fire;

   always_comb begin
      sel_value = busy_ff ? value_ff : cmd_head.value;
      sel_rem   = busy_ff ? rem_ff : cmd_head.count;
      col_inc   = col_ff + 1'b1;
      row_inc   = row_ff + 1'b1;
      wrap      = (col_inc == width_ff);
      done      = wrap && (row_inc == height_ff);
      last      = (sel_rem == rib_pkg::RUN_W'(1)) || done;
      pix_addr  = raddr_ff + ADDR_BITS'(col_ff);

      fire    = 1'b0;
      cmd_pop = 1'b0;

      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      raddr_in    = raddr_ff;
      finished_in = finished_ff;
      busy_in     = busy_ff;
      value_in    = value_ff;
      rem_in      = rem_ff;

      if (busy_ff) begin
         fire = !out_full;
      end else if (!cmd_empty) begin
         if (cmd_head.is_hdr) begin
            cmd_pop     = 1'b1;
            width_in    = cmd_head.width;
            height_in   = cmd_head.height;
            col_in      = '0;
            row_in      = '0;
            raddr_in    = ADDR_BITS'(cmd_head.base);
            finished_in = (cmd_head.width == '0) || (cmd_head.height == '0);
         end else if (finished_ff) begin
            // frame over: pixels are dropped
            cmd_pop = 1'b1;
         end else if (!out_full) begin
            cmd_pop = 1'b1;
            fire    = 1'b1;
         end
      end

      if (fire) begin
         col_in   = wrap ? '0 : col_inc;
         busy_in  = !last;
         value_in = sel_value;
         rem_in   = sel_rem - 1'b1;
         if (wrap) begin
            row_in   = row_inc;
            raddr_in = raddr_ff + ADDR_BITS'(row_pitch);
         end
         if (done) begin
            finished_in = 1'b1;
         end
      end

      out_push       = fire;
      out_data.addr  = rib_pkg::PIX_ADDR_W'(pix_addr);
      out_data.value = sel_value;
      out_data.last  = last;
      out_data.done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= '0;
         height_ff   <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         raddr_ff    <= '0;
         finished_ff <= 1'b1;
         busy_ff     <= 1'b0;
         rem_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         raddr_ff    <= raddr_in;
         finished_ff <= finished_in;
         busy_ff     <= busy_in;
         rem_ff      <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- rtl/core/rle_image_blit_decoder.sv -----
// Top level of the RLE image blit decoder: CSRs, front end, command queue, back end.
// Throughput: one beat per cycle on input while the command queue has a free slot;
//   a run value byte expands in the single back-end pixel emitter, which sets the rate;
//   header and run bytes emit nothing.
// The 4-deep command queue lets the front end keep taking beats while a run expands.
// Reset (synchronous): queues empty, CSRs zero, decoder idle until a frame_start beat.
`include "rle_image_blit_decoder_defines.svh"
module rle_image_blit_decoder #(
   parameter int ADDR_BITS = rib_pkg::ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // source byte channel
   input  logic                               push,
   output logic                               full,
   input  logic [rib_pkg::BYTE_W-1:0]         req_byte_in,
   input  logic                               req_frame_start,
   // pixel channel
   output logic                               empty,
   input  logic                               pop,
   output logic [rib_pkg::PIX_ADDR_W-1:0]     rsp_pixel_addr,
   output logic [rib_pkg::BYTE_W-1:0]         rsp_pixel_value,
   output logic                               rsp_last_of_run,
   output logic                               rsp_frame_done,
   // CSR write port
   input  logic                               csr_wr_en,
   input  logic [rib_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rib_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int CMD_W = $bits(rib_pkg::cmd_type);
   localparam int PIX_W = $bits(rib_pkg::pix_type);

   // CSRs
   logic [rib_pkg::BASE_W-1:0]  dest_base_ff;
   logic [rib_pkg::PITCH_W-1:0] row_pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_base_ff <= '0;
         row_pitch_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            rib_pkg::CSR_DEST_BASE: dest_base_ff <= csr_wdata[rib_pkg::BASE_W-1:0];
            rib_pkg::CSR_ROW_PITCH: row_pitch_ff <= csr_wdata[rib_pkg::PITCH_W-1:0];
            default:                dest_base_ff <= dest_base_ff;
         endcase
      end
   end

   // front end: a beat is taken whenever the command queue has a free slot
   logic             in_fire;
   logic             cmd_push;
   rib_pkg::cmd_type cmd_wr;
   logic             cmd_full, cmd_empty, cmd_pop;
   logic [CMD_W-1:0] cmd_rd_data;
   rib_pkg::cmd_type cmd_head;

   assign full    = cmd_full;
   assign in_fire = push && !cmd_full;

   rib_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .byte_in     (req_byte_in),
      .frame_start (req_frame_start),
      .dest_base   (dest_base_ff),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wr)
   );

   rib_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (rib_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   assign cmd_head = rib_pkg::cmd_type'(cmd_rd_data);

   // back end: expands runs, one pixel per cycle into the output queue while it has room
   logic             out_push, out_full;
   rib_pkg::pix_type out_wr;
   logic [PIX_W-1:0] out_rd_data;
   rib_pkg::pix_type out_head;
   logic             pix_done;

   rib_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .row_pitch (row_pitch_ff),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wr)
   );

   // output skid queue decouples pixel generation from the consumer
   rib_fifo #(
      .WIDTH (PIX_W),
      .DEPTH (rib_pkg::OUT_DEPTH)
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (out_rd_data),
      .empty   (empty)
   );

   assign out_head        = rib_pkg::pix_type'(out_rd_data);
   assign rsp_pixel_addr  = out_head.addr;
   assign rsp_pixel_value = out_head.value;
   assign rsp_last_of_run = out_head.last;
   assign rsp_frame_done  = out_head.done;

   // last pixel of the image leaving the back end
   assign pix_done = out_push && out_wr.done;

   // checks
   `RIB_ASSERT_SAME(a_cmd_no_overflow, clock, reset, cmd_push, !cmd_full, "cmd queue overflow")
   `RIB_ASSERT_SAME(a_out_no_overflow, clock, reset, out_push, !out_full, "out queue overflow")
   `RIB_ASSERT_SAME(a_done_is_last, clock, reset, pix_done, out_wr.last, "done without last")
   `RIB_ASSERT_NEXT(a_done_drains, clock, reset, pix_done, !out_push, "pixel after frame end")

endmodule
